>>> sv/cart_bank_mapper_with_scanline_irq_defines.svh
// assertion macros shared by the mapper rtl
`ifndef CART_BANK_MAPPER_WITH_SCANLINE_IRQ_DEFINES_SVH
`define CART_BANK_MAPPER_WITH_SCANLINE_IRQ_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CBM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cbm assertion failed");
// next-cycle implication
`define CBM_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cbm assertion failed");
`else
`define CBM_ASSERT_IMP(label, clk, rstn, ante, cons)
`define CBM_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

>>> sv/cbm_pkg.sv
package cbm_pkg;

    // item kinds
    localparam logic [1:0] MODE_WRITE    = 2'd0;
    localparam logic [1:0] MODE_TICK     = 2'd1;
    localparam logic [1:0] MODE_PRG_LOOK = 2'd2;
    localparam logic [1:0] MODE_CHR_LOOK = 2'd3;

    // register decode on address bits 14:13 and 0
    localparam logic [2:0] REG_BANK_SELECT = 3'b000;
    localparam logic [2:0] REG_BANK_DATA   = 3'b001;
    localparam logic [2:0] REG_IRQ_COUNTER = 3'b100;
    localparam logic [2:0] REG_IRQ_RELOAD  = 3'b101;
    localparam logic [2:0] REG_IRQ_DISABLE = 3'b110;
    localparam logic [2:0] REG_IRQ_ENABLE  = 3'b111;

    // bank data targets
    localparam logic [2:0] SLOT_CHR_PAIR0 = 3'd0;
    localparam logic [2:0] SLOT_CHR_PAIR1 = 3'd1;
    localparam logic [2:0] SLOT_CHR_FIRST = 3'd2;
    localparam logic [2:0] SLOT_CHR_LAST  = 3'd5;
    localparam logic [2:0] SLOT_PRG_FIRST = 3'd6;
    localparam logic [2:0] SLOT_PRG_SECOND = 3'd7;

    localparam int          CHR_ENTRIES   = 8;
    localparam logic [8:0]  PRG_COUNT_RST = 9'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] bus_address;
        logic [7:0]  write_value;
        logic        in_vblank;
    } item_t;

    typedef struct packed {
        logic        irq_request;
        logic [8:0]  bank_number;
        logic [12:0] bank_offset;
        logic        lookup_valid;
        logic        nametable_page;
    } result_t;

endpackage

>>> sv/cbm_core.sv
`include "cart_bank_mapper_with_scanline_irq_defines.svh"

module cbm_core
    import cbm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  item_t      item,
    input  logic [8:0] prg_16k_bank_count,
    output result_t    res
);

    logic [7:0] bank_select_reg,     bank_select_next;
    logic [7:0] chr_slot_banks_reg   [CHR_ENTRIES];
    logic [7:0] chr_slot_banks_next  [CHR_ENTRIES];
    logic [7:0] prg_bank_first_reg,  prg_bank_first_next;
    logic [7:0] prg_bank_second_reg, prg_bank_second_next;
    logic       irq_enabled_reg,     irq_enabled_next;
    logic [7:0] irq_counter_reg,     irq_counter_next;
    logic [7:0] irq_reload_reg,      irq_reload_next;
    logic       screen_page_reg,     screen_page_next;

    logic [2:0] reg_code;
    logic [2:0] data_slot;
    logic [2:0] chr_index;
    logic [8:0] prg_last;
    logic [8:0] prg_prev;
    logic       prg_swap;

    assign reg_code  = {item.bus_address[14:13], item.bus_address[0]};
    assign data_slot = bank_select_reg[2:0];
    assign chr_index = item.bus_address[12:10] ^ {bank_select_reg[7], 2'b00};
    assign prg_last  = {prg_16k_bank_count[7:0], 1'b0} - 9'd1;
    assign prg_prev  = prg_last - 9'd1;
    assign prg_swap  = bank_select_reg[6];

    always_comb begin
        bank_select_next     = bank_select_reg;
        chr_slot_banks_next  = chr_slot_banks_reg;
        prg_bank_first_next  = prg_bank_first_reg;
        prg_bank_second_next = prg_bank_second_reg;
        irq_enabled_next     = irq_enabled_reg;
        irq_counter_next     = irq_counter_reg;
        irq_reload_next      = irq_reload_reg;
        screen_page_next     = screen_page_reg;
        res                  = '0;

        case (item.mode)
            MODE_WRITE: begin
                if (item.bus_address[15]) begin
                    unique case (reg_code)
                        REG_BANK_SELECT: bank_select_next = item.write_value;
                        REG_BANK_DATA: begin
                            if (data_slot[2:1] != 2'b11) begin
                                screen_page_next = item.write_value[7];
                            end
                            case (data_slot) inside
                                SLOT_CHR_PAIR0: begin
                                    chr_slot_banks_next[0] = {item.write_value[7:1], 1'b0};
                                    chr_slot_banks_next[1] = {item.write_value[7:1], 1'b1};
                                end
                                SLOT_CHR_PAIR1: begin
                                    chr_slot_banks_next[2] = {item.write_value[7:1], 1'b0};
                                    chr_slot_banks_next[3] = {item.write_value[7:1], 1'b1};
                                end
                                [SLOT_CHR_FIRST:SLOT_CHR_LAST]: begin
                                    chr_slot_banks_next[data_slot + 3'd2] = item.write_value;
                                end
                                SLOT_PRG_FIRST:  prg_bank_first_next  = item.write_value;
                                SLOT_PRG_SECOND: prg_bank_second_next = item.write_value;
                                default: ;
                            endcase
                        end
                        REG_IRQ_COUNTER: irq_counter_next = item.write_value;
                        REG_IRQ_RELOAD:  irq_reload_next  = item.write_value;
                        REG_IRQ_DISABLE: irq_enabled_next = 1'b0;
                        REG_IRQ_ENABLE:  irq_enabled_next = 1'b1;
                        // mirroring registers, not used here
                        default: ;
                    endcase
                end
            end
            MODE_TICK: begin
                if (irq_enabled_reg && !item.in_vblank) begin
                    if (irq_counter_reg == 8'd0) begin
                        irq_counter_next = irq_reload_reg;
                        res.irq_request  = 1'b1;
                    end else begin
                        irq_counter_next = irq_counter_reg - 8'd1;
                    end
                end
            end
            MODE_PRG_LOOK: begin
                if (item.bus_address[15]) begin
                    case (item.bus_address[14:13])
                        2'd0:    res.bank_number = prg_swap ? prg_prev
                                                            : {1'b0, prg_bank_first_reg};
                        2'd1:    res.bank_number = {1'b0, prg_bank_second_reg};
                        2'd2:    res.bank_number = prg_swap ? {1'b0, prg_bank_first_reg}
                                                            : prg_prev;
                        default: res.bank_number = prg_last;
                    endcase
                    res.bank_offset  = item.bus_address[12:0];
                    res.lookup_valid = 1'b1;
                end
            end
            default: begin
                if (item.bus_address[15:13] == 3'd0) begin
                    res.bank_number  = {1'b0, chr_slot_banks_reg[chr_index]};
                    res.bank_offset  = {3'd0, item.bus_address[9:0]};
                    res.lookup_valid = 1'b1;
                end
            end
        endcase

        res.nametable_page = screen_page_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_select_reg     <= '0;
            for (int i = 0; i < CHR_ENTRIES; i++) begin
                chr_slot_banks_reg[i] <= 8'(i);
            end
            prg_bank_first_reg  <= 8'd0;
            prg_bank_second_reg <= 8'd1;
            irq_enabled_reg     <= 1'b0;
            irq_counter_reg     <= '0;
            irq_reload_reg      <= '0;
            screen_page_reg     <= 1'b0;
        end else if (fire) begin
            bank_select_reg     <= bank_select_next;
            chr_slot_banks_reg  <= chr_slot_banks_next;
            prg_bank_first_reg  <= prg_bank_first_next;
            prg_bank_second_reg <= prg_bank_second_next;
            irq_enabled_reg     <= irq_enabled_next;
            irq_counter_reg     <= irq_counter_next;
            irq_reload_reg      <= irq_reload_next;
            screen_page_reg     <= screen_page_next;
        end
    end

    `CBM_ASSERT_NXT(a_tick_reload, aclk, aresetn,
        fire && item.mode == MODE_TICK && irq_enabled_reg && !item.in_vblank
            && irq_counter_reg == 8'd0,
        irq_counter_reg == $past(irq_reload_reg))
    `CBM_ASSERT_IMP(a_irq_only_on_tick, aclk, aresetn,
        res.irq_request,
        item.mode == MODE_TICK && irq_enabled_reg && irq_counter_reg == 8'd0)
    `CBM_ASSERT_IMP(a_chr_pairs, aclk, aresetn,
        1'b1,
        !chr_slot_banks_reg[0][0] && chr_slot_banks_reg[1] == {chr_slot_banks_reg[0][7:1], 1'b1}
            && !chr_slot_banks_reg[2][0]
            && chr_slot_banks_reg[3] == {chr_slot_banks_reg[2][7:1], 1'b1})

endmodule

>>> sv/cart_bank_mapper_with_scanline_irq.sv
// channel  direction  handshake            payload
// s_       in         s_tvalid / s_tready  bus events: write, tick, prg or chr lookup
// m_       out        m_tvalid / m_tready  one result transaction per event
// cfg_     in         cfg_valid / cfg_ready prg_16k_bank_count
//
// one transaction per cycle sustained while m_tready is high; m_tvalid rises once the
// event has gone through the input register, then mapper logic into the result register
// synchronous active-low reset returns all bank, irq and config state to defaults
// a stall on m_ backs up through the two registers to s_tready; cfg_ready is always high

`include "cart_bank_mapper_with_scanline_irq_defines.svh"

module cart_bank_mapper_with_scanline_irq
    import cbm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // bus_address, write_value, in_vblank, zero pad
    input  logic [1:0]  s_tuser,   // mode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // irq_request, bank_number, bank_offset, nametable_page
    output logic        m_tuser,   // lookup_valid

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data
);

    logic       in_valid_reg;
    item_t      item_reg;
    logic       out_valid_reg;
    result_t    res_reg;
    logic [8:0] prg_count_reg;
    result_t    core_res;
    logic       fire;

    assign fire      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prg_count_reg <= PRG_COUNT_RST;
        end else begin
            if (cfg_valid) begin
                prg_count_reg <= cfg_data;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.mode        <= s_tuser;
            item_reg.bus_address <= s_tdata[15:0];
            item_reg.write_value <= s_tdata[23:16];
            item_reg.in_vblank   <= s_tdata[24];
        end
        if (fire) begin
            res_reg <= core_res;
        end
    end

    cbm_core u_core (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .fire               (fire),
        .item               (item_reg),
        .prg_16k_bank_count (prg_count_reg),
        .res                (core_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {res_reg.nametable_page, res_reg.bank_offset,
                       res_reg.bank_number, res_reg.irq_request};
    assign m_tuser  = res_reg.lookup_valid;

    `CBM_ASSERT_NXT(a_fire_fills_output, aclk, aresetn,
        fire,
        out_valid_reg)
    `CBM_ASSERT_NXT(a_held_item_stable, aclk, aresetn,
        in_valid_reg && !fire,
        in_valid_reg && $stable(item_reg))
    `CBM_ASSERT_NXT(a_write_gives_no_lookup, aclk, aresetn,
        fire && item_reg.mode == MODE_WRITE,
        !res_reg.lookup_valid && !res_reg.irq_request && res_reg.bank_number == 9'd0)

endmodule
